// File: src/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, codes and default sizes for the reference-counted page
// allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int NUM_PAGES_DEF   = 4096;
    localparam int PAGE_SHIFT_DEF  = 12;
    localparam int COUNT_WIDTH_DEF = 8;

    localparam int REQ_W       = 3;
    localparam int ADDR_W      = 32;
    localparam int KEND_W      = 24;
    localparam int PAGE_ADDR_W = 24;
    localparam int REFC_W      = 8;
    localparam int FREEC_W     = 13;
    localparam int STATUS_W    = 3;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int CFG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = '0;

    typedef logic [REQ_W-1:0] req_t;

    localparam req_t REQ_INIT  = 3'd0;
    localparam req_t REQ_ALLOC = 3'd1;
    localparam req_t REQ_FREE  = 3'd2;
    localparam req_t REQ_INC   = 3'd3;
    localparam req_t REQ_DEC   = 3'd4;
    localparam req_t REQ_GET   = 3'd5;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK      = 3'd0;
    localparam status_t STATUS_BAD     = 3'd1;
    localparam status_t STATUS_NOPAGE  = 3'd2;
    localparam status_t STATUS_LIMIT   = 3'd3;
    localparam status_t STATUS_FULL    = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep_init;
        logic sweep_step;
        logic sweep_push;
        logic load_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_init;
        logic sweep_last;
        logic out_free;
    } dp_sts_t;

endpackage

// File: src/rpa_cfg.sv
// ----------------------------------------------------------------------------
// rpa_cfg
// APB register slave holding the kernel end address.
// ----------------------------------------------------------------------------
module rpa_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [rpa_pkg::KEND_W-1:0]      kernel_end
);

    logic [rpa_pkg::KEND_W-1:0]    kend_reg;
    logic [rpa_pkg::KEND_W-1:0]    kend_next;
    logic [rpa_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign reg_idx = paddr[rpa_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        kend_next = kend_reg;
        if (wr_en && reg_idx == rpa_pkg::CFG_KERNEL_END) begin
            kend_next = pwdata[rpa_pkg::KEND_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kend_reg <= '0;
        end else begin
            kend_reg <= kend_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            rpa_pkg::CFG_KERNEL_END: begin
                prdata = rpa_pkg::APB_DATA_W'(kend_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign kernel_end = kend_reg;

endmodule

// File: src/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: reset clearing pass, accept, execute, init sweep and result load.
// ----------------------------------------------------------------------------
module rpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  rpa_pkg::dp_sts_t   sts,
    output rpa_pkg::ctrl_cmd_t cmd
);

    rpa_pkg::state_t state_reg;
    rpa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpa_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            rpa_pkg::ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = rpa_pkg::ST_IDLE;
                end
            end
            rpa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = rpa_pkg::ST_EXEC;
                end
            end
            rpa_pkg::ST_EXEC: begin
                if (sts.is_init) begin
                    cmd.sweep_init = 1'b1;
                    state_next     = rpa_pkg::ST_SWEEP;
                end else if (sts.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = rpa_pkg::ST_IDLE;
                end
            end
            rpa_pkg::ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_push = 1'b1;
                if (sts.sweep_last) begin
                    state_next = rpa_pkg::ST_FINISH;
                end
            end
            rpa_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.load_done = 1'b1;
                    state_next    = rpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rpa_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: src/rpa_dp.sv
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: free stack and count memories, request checks, read-modify-write
// and the result register.
// ----------------------------------------------------------------------------
module rpa_dp #(
    parameter int NUM_PAGES   = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rpa_pkg::ctrl_cmd_t             cmd,
    output rpa_pkg::dp_sts_t               sts,
    input  logic [rpa_pkg::REQ_W-1:0]      s_tuser,
    input  logic [rpa_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [rpa_pkg::KEND_W-1:0]     kernel_end,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rpa_pkg::STATUS_W-1:0]   m_tuser,
    output logic [rpa_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W   = $clog2(NUM_PAGES);
    localparam int TOP_W   = $clog2(NUM_PAGES + 1);
    localparam int AW      = rpa_pkg::ADDR_W;
    localparam int AW1     = AW + 1;
    localparam int START_W = rpa_pkg::KEND_W + 1;
    localparam int FCW     = rpa_pkg::FREEC_W;
    localparam int RCW     = rpa_pkg::REFC_W;
    localparam int PAW     = rpa_pkg::PAGE_ADDR_W;
    localparam int PAD_W   = rpa_pkg::M_TDATA_W - PAW - RCW - FCW;

    localparam logic [AW1-1:0]         NP_EXT    = AW1'(NUM_PAGES);
    localparam logic [AW1-1:0]         MEM_TOP   = NP_EXT << PAGE_SHIFT;
    localparam logic [START_W-1:0]     PAGE_MASK = START_W'((1 << PAGE_SHIFT) - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [TOP_W-1:0]       TOP_FULL  = TOP_W'(NUM_PAGES);
    localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_PAGES - 1);

    logic [IDX_W-1:0]       stk_mem [NUM_PAGES];
    logic [COUNT_WIDTH-1:0] ref_mem [NUM_PAGES];

    logic [rpa_pkg::REQ_W-1:0]    req_reg;
    logic [AW-1:0]                addr_reg;
    logic [COUNT_WIDTH-1:0]       cnt_rd_reg;
    logic [IDX_W-1:0]             stk_rd_reg;
    logic [TOP_W-1:0]             top_reg;
    logic [TOP_W-1:0]             top_next;
    logic [IDX_W-1:0]             sweep_reg;
    logic [IDX_W-1:0]             sweep_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [rpa_pkg::STATUS_W-1:0] m_user_reg;
    logic [rpa_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [IDX_W-1:0]       idx_in;
    logic [IDX_W-1:0]       idx_reg;
    logic [TOP_W-1:0]       top_m1;
    logic [AW1-1:0]         addr_ext;
    logic                   in_bounds;
    logic                   aligned;
    logic [AW-1:0]          page32;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic [START_W-1:0]     start_pg;
    logic                   sweep_push_now;

    rpa_pkg::status_t       ex_status;
    logic [PAW-1:0]         ex_page;
    logic [RCW-1:0]         ex_refc;
    logic [TOP_W-1:0]       ex_top;
    logic                   ex_ref_we;
    logic [IDX_W-1:0]       ex_ref_wa;
    logic [COUNT_WIDTH-1:0] ex_ref_wd;
    logic                   ex_push;

    logic                   ref_we;
    logic [IDX_W-1:0]       ref_wa;
    logic [COUNT_WIDTH-1:0] ref_wd;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_wd;

    assign idx_in    = s_tdata[PAGE_SHIFT +: IDX_W];
    assign idx_reg   = addr_reg[PAGE_SHIFT +: IDX_W];
    assign top_m1    = top_reg - 1'b1;
    assign addr_ext  = AW1'(addr_reg);
    assign in_bounds = (addr_ext >= AW1'(kernel_end)) && (addr_ext < MEM_TOP);
    assign aligned   = (addr_reg[PAGE_SHIFT-1:0] == '0);
    assign page32    = AW'(stk_rd_reg) << PAGE_SHIFT;
    assign cnt_dec   = (cnt_rd_reg != '0) ? cnt_rd_reg - 1'b1 : cnt_rd_reg;
    assign start_pg  = (START_W'(kernel_end) + PAGE_MASK) >> PAGE_SHIFT;
    assign sweep_push_now = cmd.sweep_push && (START_W'(sweep_reg) >= start_pg);

    always_comb begin
        ex_status = rpa_pkg::STATUS_OK;
        ex_page   = '0;
        ex_refc   = '0;
        ex_top    = top_reg;
        ex_ref_we = 1'b0;
        ex_ref_wa = idx_reg;
        ex_ref_wd = cnt_rd_reg;
        ex_push   = 1'b0;
        case (req_reg)
            rpa_pkg::REQ_ALLOC: begin
                if (top_reg == '0) begin
                    ex_status = rpa_pkg::STATUS_NOPAGE;
                end else begin
                    ex_top    = top_m1;
                    ex_ref_we = 1'b1;
                    ex_ref_wa = stk_rd_reg;
                    ex_ref_wd = COUNT_WIDTH'(1);
                    ex_page   = page32[PAW-1:0];
                end
            end
            rpa_pkg::REQ_FREE: begin
                if (!aligned || !in_bounds) begin
                    ex_status = rpa_pkg::STATUS_BAD;
                end else begin
                    ex_ref_we = 1'b1;
                    ex_ref_wd = cnt_dec;
                    if (cnt_dec == '0) begin
                        if (top_reg < TOP_FULL) begin
                            ex_push = 1'b1;
                            ex_top  = top_reg + 1'b1;
                        end else begin
                            ex_status = rpa_pkg::STATUS_FULL;
                        end
                    end
                end
            end
            rpa_pkg::REQ_INC: begin
                if (!in_bounds) begin
                    ex_status = rpa_pkg::STATUS_BAD;
                end else if (cnt_rd_reg == COUNT_MAX) begin
                    ex_status = rpa_pkg::STATUS_LIMIT;
                end else begin
                    ex_ref_we = 1'b1;
                    ex_ref_wd = cnt_rd_reg + 1'b1;
                end
            end
            rpa_pkg::REQ_DEC: begin
                if (!in_bounds) begin
                    ex_status = rpa_pkg::STATUS_BAD;
                end else if (cnt_rd_reg == '0) begin
                    ex_status = rpa_pkg::STATUS_LIMIT;
                end else begin
                    ex_ref_we = 1'b1;
                    ex_ref_wd = cnt_dec;
                end
            end
            rpa_pkg::REQ_GET: begin
                if (!in_bounds) begin
                    ex_status = rpa_pkg::STATUS_BAD;
                end else begin
                    ex_refc = RCW'(cnt_rd_reg);
                end
            end
            default: begin
                ex_status = rpa_pkg::STATUS_OK;
            end
        endcase
    end

    assign ref_we = cmd.sweep_step || (cmd.exec && ex_ref_we);
    assign ref_wa = cmd.sweep_step ? sweep_reg : ex_ref_wa;
    assign ref_wd = cmd.sweep_step ? '0 : ex_ref_wd;
    assign stk_we = (cmd.sweep_step && sweep_push_now) || (cmd.exec && ex_push);
    assign stk_wd = cmd.sweep_step ? sweep_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (cmd.accept) begin
            cnt_rd_reg <= ref_mem[idx_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[top_reg[IDX_W-1:0]] <= stk_wd;
        end
        if (cmd.accept) begin
            stk_rd_reg <= stk_mem[top_m1[IDX_W-1:0]];
        end
    end

    always_comb begin
        top_next = top_reg;
        if (cmd.sweep_init) begin
            top_next = '0;
        end else if (cmd.sweep_step && sweep_push_now) begin
            top_next = top_reg + 1'b1;
        end else if (cmd.exec) begin
            top_next = ex_top;
        end
    end

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep_init) begin
            sweep_next = '0;
        end else if (cmd.sweep_step) begin
            sweep_next = (sweep_reg == LAST_IDX) ? '0 : sweep_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec || cmd.load_done) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            top_reg     <= top_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg  <= s_tuser;
            addr_reg <= s_tdata;
        end
        if (cmd.exec) begin
            m_user_reg <= ex_status;
            m_data_reg <= {{PAD_W{1'b0}}, FCW'(ex_top), ex_refc, ex_page};
        end else if (cmd.load_done) begin
            m_user_reg <= rpa_pkg::STATUS_OK;
            m_data_reg <= {{PAD_W{1'b0}}, FCW'(top_reg), {RCW{1'b0}}, {PAW{1'b0}}};
        end
    end

    assign sts.is_init    = (req_reg == rpa_pkg::REQ_INIT);
    assign sts.sweep_last = (sweep_reg == LAST_IDX);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: src/refcounted_page_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page allocator with a LIFO free stack and per-page reference counts.
// Alloc, free, inc, dec and get are registered on accept with the count and
// stack reads; execute loads the result, raising m_tvalid, once the output is
// free. Init sweeps one page per cycle through the count memory, then loads
// the free count. One request at a time: s_tready stays low from accept until
// the read-modify-write of the count and stack memories is done. Reset: a
// clearing pass zeroes every count, s_tready low; the free stack starts empty.
// ----------------------------------------------------------------------------
module refcounted_page_allocator #(
    parameter int NUM_PAGES   = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tuser: [2:0] req_type
    input  logic [rpa_pkg::REQ_W-1:0]       s_tuser,
    // s_tdata: [31:0] phys_address
    input  logic [rpa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tuser: [2:0] status
    output logic [rpa_pkg::STATUS_W-1:0]    m_tuser,
    // m_tdata: [23:0] page_address, [31:24] ref_count, [44:32] free_count,
    //          [47:45] zero
    output logic [rpa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    rpa_pkg::ctrl_cmd_t             cmd;
    rpa_pkg::dp_sts_t               sts;
    logic [rpa_pkg::KEND_W-1:0]     kernel_end;

    rpa_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .kernel_end (kernel_end)
    );

    rpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpa_dp #(
        .NUM_PAGES   (NUM_PAGES),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .kernel_end (kernel_end),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata)
    );

    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high in the cycle after an accepted transaction");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(cmd.exec || cmd.load_done))
        else $error("result register loaded while a result is stalled");

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.load_done) |=> m_tvalid)
        else $error("executed request produced no result");

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_step |-> !s_tready)
        else $error("input ready during a sweep");

endmodule

// File: dv/tb_refcounted_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_page_allocator
// Self-checking testbench for the reference-counted page allocator. A
// behavioral copy of the free stack, the per-page counts and the kernel end
// register predicts every reply. Each reply is checked field by field against
// the oldest prediction. Directed tests cover the error statuses and the
// kernel end bounds, then count saturation and output backpressure. Random
// traffic follows under several kernel end settings, with random idle cycles
// on both stream sides in four of the six phases.
// ----------------------------------------------------------------------------
module tb_refcounted_page_allocator;

    localparam int NUM_PAGES   = rpa_pkg::NUM_PAGES_DEF;
    localparam int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF;
    localparam int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF;
    localparam int PAGE_MASK   = (1 << PAGE_SHIFT) - 1;
    localparam int IDX_W       = $clog2(NUM_PAGES);
    localparam int AW          = rpa_pkg::ADDR_W;
    localparam int PAW         = rpa_pkg::PAGE_ADDR_W;
    localparam int RCW         = rpa_pkg::REFC_W;
    localparam int FCW         = rpa_pkg::FREEC_W;
    localparam int KW          = rpa_pkg::KEND_W;
    localparam int PDW         = rpa_pkg::APB_DATA_W;

    localparam logic [AW-1:0]          MEM_TOP   = AW'(NUM_PAGES) << PAGE_SHIFT;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam rpa_pkg::req_t REQ_RSVD_A = 3'd6;
    localparam rpa_pkg::req_t REQ_RSVD_B = 3'd7;

    localparam logic [rpa_pkg::APB_ADDR_W-1:0] KERNEL_END_ADDR =
        {rpa_pkg::CFG_KERNEL_END, 2'b00};

    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int MAX_REPORTS    = 10;
    localparam int LIVE_PAGES_MAX = 32;

    typedef struct packed {
        rpa_pkg::status_t        status;
        logic [PAW-1:0]          page_address;
        logic [RCW-1:0]          ref_count;
        logic [FCW-1:0]          free_count;
    } page_reply_t;

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic [rpa_pkg::REQ_W-1:0]         s_tuser  = '0;
    logic [rpa_pkg::S_TDATA_W-1:0]     s_tdata  = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [rpa_pkg::STATUS_W-1:0]      m_tuser;
    logic [rpa_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [rpa_pkg::APB_ADDR_W-1:0]    paddr    = '0;
    logic [PDW-1:0]                    pwdata   = '0;
    logic [PDW-1:0]                    prdata;
    logic                              pready;

    logic [IDX_W-1:0]        model_stack  [NUM_PAGES];
    logic [COUNT_WIDTH-1:0]  model_counts [NUM_PAGES];
    logic [FCW-1:0]          model_top  = '0;
    logic [KW-1:0]           model_kend = '0;

    page_reply_t             pending_results [$];
    logic [AW-1:0]           live_pages [$];

    bit                      src_idle_on  = 1'b1;
    bit                      sink_idle_on = 1'b1;
    bit                      hold_sink    = 1'b0;
    int                      error_count  = 0;
    int                      cycle_count  = 0;

    refcounted_page_allocator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic page_reply_t allocator_step(input rpa_pkg::req_t req,
                                                   input logic [AW-1:0] addr);
        page_reply_t      r;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] pg;
        logic             in_range;
        int               first;
        r        = '0;
        idx      = addr[PAGE_SHIFT +: IDX_W];
        in_range = (addr >= AW'(model_kend)) && (addr < MEM_TOP);
        case (req)
            rpa_pkg::REQ_INIT: begin
                first     = (int'(model_kend) + PAGE_MASK) >> PAGE_SHIFT;
                model_top = '0;
                for (int p = 0; p < NUM_PAGES; p++) begin
                    model_counts[p] = '0;
                    if (p >= first) begin
                        model_stack[model_top] = IDX_W'(p);
                        model_top++;
                    end
                end
            end
            rpa_pkg::REQ_ALLOC: begin
                if (model_top == 0) begin
                    r.status = rpa_pkg::STATUS_NOPAGE;
                end else begin
                    model_top--;
                    pg               = model_stack[model_top];
                    model_counts[pg] = 1;
                    r.page_address   = PAW'(AW'(pg) << PAGE_SHIFT);
                end
            end
            rpa_pkg::REQ_FREE: begin
                if (addr[PAGE_SHIFT-1:0] != 0 || !in_range) begin
                    r.status = rpa_pkg::STATUS_BAD;
                end else begin
                    if (model_counts[idx] != 0) model_counts[idx]--;
                    if (model_counts[idx] == 0) begin
                        if (model_top >= NUM_PAGES) begin
                            r.status = rpa_pkg::STATUS_FULL;
                        end else begin
                            model_stack[model_top] = idx;
                            model_top++;
                        end
                    end
                end
            end
            rpa_pkg::REQ_INC: begin
                if (!in_range) r.status = rpa_pkg::STATUS_BAD;
                else if (model_counts[idx] == COUNT_MAX) r.status = rpa_pkg::STATUS_LIMIT;
                else model_counts[idx]++;
            end
            rpa_pkg::REQ_DEC: begin
                if (!in_range) r.status = rpa_pkg::STATUS_BAD;
                else if (model_counts[idx] == 0) r.status = rpa_pkg::STATUS_LIMIT;
                else model_counts[idx]--;
            end
            rpa_pkg::REQ_GET: begin
                if (!in_range) r.status = rpa_pkg::STATUS_BAD;
                else r.ref_count = RCW'(model_counts[idx]);
            end
            default: begin
            end
        endcase
        r.free_count = model_top;
        return r;
    endfunction

    task automatic issue_request(input rpa_pkg::req_t req, input logic [AW-1:0] addr);
        int          gap;
        page_reply_t want;
        gap = src_idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        want = allocator_step(req, addr);
        pending_results.push_back(want);
        if (req == rpa_pkg::REQ_INIT) begin
            live_pages.delete();
        end else if (req == rpa_pkg::REQ_ALLOC && want.status == rpa_pkg::STATUS_OK) begin
            live_pages.push_back(AW'(want.page_address));
            if (live_pages.size() > LIVE_PAGES_MAX) void'(live_pages.pop_front());
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_kernel_end(input logic [KW-1:0] value);
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= KERNEL_END_ADDR;
        pwdata  <= PDW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_kend = value;
        @(posedge aclk);
        psel    <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== PDW'(value)) begin
            flag_error($sformatf("kernel end readback exp %h act %h", value, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [AW-1:0] pick_address();
        logic [AW-1:0] base;
        if (live_pages.size() != 0) begin
            base = live_pages[$urandom_range(0, live_pages.size() - 1)];
        end else begin
            base = AW'({IDX_W'($urandom), PAGE_SHIFT'(0)});
        end
        case ($urandom_range(0, 15))
            0:       return $urandom();
            1:       return AW'(model_kend) - AW'($urandom_range(0, 1));
            2:       return MEM_TOP - AW'($urandom_range(0, PAGE_MASK + 1));
            3:       return base | AW'($urandom_range(1, PAGE_MASK));
            4, 5:    return AW'({IDX_W'($urandom), PAGE_SHIFT'(0)});
            default: return base;
        endcase
    endfunction

    function automatic rpa_pkg::req_t pick_request();
        int w;
        w = $urandom_range(0, 99);
        if (w < 30) return rpa_pkg::REQ_ALLOC;
        if (w < 55) return rpa_pkg::REQ_FREE;
        if (w < 70) return rpa_pkg::REQ_INC;
        if (w < 80) return rpa_pkg::REQ_DEC;
        if (w < 93) return rpa_pkg::REQ_GET;
        if (w < 95) return $urandom_range(0, 1) ? REQ_RSVD_A : REQ_RSVD_B;
        if (w < 99) return rpa_pkg::req_t'($urandom_range(0, 7));
        return rpa_pkg::REQ_INIT;
    endfunction

    // sink side: random idle per transaction, long hold on request
    initial begin : sink_driver
        int gap;
        forever begin
            gap = sink_idle_on ? $urandom_range(0, 6) : 0;
            if (hold_sink) begin
                gap       = HOLD_CYCLES;
                hold_sink = 1'b0;
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : result_check
        page_reply_t want;
        string       exp_s;
        string       act_s;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected reply status %0d data %h", m_tuser, m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status || m_tdata[23:0] !== want.page_address
                        || m_tdata[31:24] !== want.ref_count
                        || m_tdata[44:32] !== want.free_count || m_tdata[47:45] !== 3'b000) begin
                    exp_s = $sformatf("status %0d page %h ref %0d free %0d",
                        want.status, want.page_address, want.ref_count, want.free_count);
                    act_s = $sformatf("status %0d page %h ref %0d free %0d pad %b",
                        m_tuser, m_tdata[23:0], m_tdata[31:24], m_tdata[44:32],
                        m_tdata[47:45]);
                    flag_error({"exp ", exp_s, ", act ", act_s});
                end
            end
        end
    end

    task automatic test_directed();
        set_kernel_end(24'h000000);
        issue_request(rpa_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(rpa_pkg::REQ_GET,   32'h0000_0000);
        issue_request(rpa_pkg::REQ_DEC,   32'h0000_0000);
        issue_request(rpa_pkg::REQ_INC,   32'h0000_0000);
        issue_request(rpa_pkg::REQ_FREE,  32'h0000_0000);
        issue_request(rpa_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
        issue_request(rpa_pkg::REQ_INIT,  32'h0000_0000);
        issue_request(rpa_pkg::REQ_FREE,  32'h0000_1000);
        issue_request(rpa_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(rpa_pkg::REQ_INC,   32'h00FF_F000);
        issue_request(rpa_pkg::REQ_GET,   32'h00FF_F123);
        issue_request(rpa_pkg::REQ_FREE,  32'h00FF_F001);
        issue_request(rpa_pkg::REQ_FREE,  32'h00FF_F000);
        issue_request(rpa_pkg::REQ_DEC,   32'h00FF_F000);
        issue_request(rpa_pkg::REQ_DEC,   32'h00FF_F000);
        issue_request(rpa_pkg::REQ_GET,   32'h0100_0000);
        issue_request(rpa_pkg::REQ_INC,   32'hFFFF_FFFF);
        issue_request(rpa_pkg::REQ_FREE,  32'h0100_0000);
        issue_request(rpa_pkg::REQ_DEC,   32'h00FF_FFFF);
        issue_request(REQ_RSVD_A,         32'hFFFF_FFFF);
        issue_request(REQ_RSVD_B,         32'h0000_0000);
        issue_request(rpa_pkg::REQ_GET,   32'h00FF_FFFF);
    endtask

    task automatic test_kernel_end_bounds();
        set_kernel_end(24'hFFF001);
        issue_request(rpa_pkg::REQ_INIT,  32'h0000_0000);
        issue_request(rpa_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(rpa_pkg::REQ_INC,   32'h00FF_F000);
        issue_request(rpa_pkg::REQ_INC,   32'h00FF_F001);
        issue_request(rpa_pkg::REQ_GET,   32'h00FF_F800);
        issue_request(rpa_pkg::REQ_FREE,  32'h00FF_F000);
        set_kernel_end(24'hFFF000);
        issue_request(rpa_pkg::REQ_INIT,  32'h0000_0000);
        issue_request(rpa_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(rpa_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(rpa_pkg::REQ_FREE,  32'h00FF_F000);
        set_kernel_end(24'hFFFFFF);
        issue_request(rpa_pkg::REQ_INIT,  32'h0000_0000);
        issue_request(rpa_pkg::REQ_GET,   32'h00FF_FFFF);
        issue_request(rpa_pkg::REQ_GET,   32'h00FF_FFFE);
    endtask

    task automatic test_count_limits();
        set_kernel_end(24'hFFE000);
        issue_request(rpa_pkg::REQ_INIT,  32'h0000_0000);
        issue_request(rpa_pkg::REQ_ALLOC, 32'h0000_0000);
        repeat (256) issue_request(rpa_pkg::REQ_INC, 32'h00FF_F000);
        issue_request(rpa_pkg::REQ_GET,   32'h00FF_F000);
        issue_request(rpa_pkg::REQ_FREE,  32'h00FF_F000);
        repeat (2) issue_request(rpa_pkg::REQ_DEC, 32'h00FF_F000);
        issue_request(rpa_pkg::REQ_GET,   32'h00FF_F000);
    endtask

    task automatic test_output_backpressure();
        drain_results();
        src_idle_on = 1'b0;
        hold_sink   = 1'b1;
        repeat (40) begin
            issue_request($urandom_range(0, 1) ? rpa_pkg::REQ_GET : rpa_pkg::REQ_INC,
                          pick_address());
        end
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [KW-1:0] kend_list [6];
        kend_list[0] = 24'h000000;
        kend_list[1] = 24'hFFFFFF;
        kend_list[2] = 24'hFE0001;
        kend_list[3] = 24'hFF8000;
        kend_list[4] = KW'($urandom);
        kend_list[5] = 24'hF00000 | KW'($urandom_range(0, 24'h0FFFFF));
        for (int ph = 0; ph < 6; ph++) begin
            set_kernel_end(kend_list[ph]);
            src_idle_on  = (ph % 3 != 2);
            sink_idle_on = (ph % 3 != 2);
            issue_request(rpa_pkg::REQ_INIT, $urandom());
            repeat (160) issue_request(pick_request(), pick_address());
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        for (int p = 0; p < NUM_PAGES; p++) begin
            model_stack[p]  = '0;
            model_counts[p] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_kernel_end_bounds();
        test_count_limits();
        test_output_backpressure();
        test_random_traffic();
        drain_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
